// ===== hdl/http_header_name_classifier_unit_macros.svh =====
// Assertion macros for the HTTP header name classifier.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef HTTP_HEADER_NAME_CLASSIFIER_UNIT_MACROS_SVH
`define HTTP_HEADER_NAME_CLASSIFIER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every rising edge of clk, ignored while rst_n is low.
`define HHNC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check prop on every rising edge of clk, reset included.
`define HHNC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HHNC_ASSERT(label, prop)
`define HHNC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== hdl/hhnc_pkg.sv =====
// Shared types, name table and helpers for the HTTP header name classifier.
// No dependencies; used by hhnc_match and http_header_name_classifier_unit.
package hhnc_pkg;

  localparam int NUM_NAMES  = 25;
  localparam int NAME_BYTES = 32;

  typedef logic [NUM_NAMES-1:0] mask_t;
  typedef logic [4:0]           code_t;
  typedef logic [4:0]           pos_t;
  typedef logic [7:0]           byte_t;
  typedef logic [NAME_BYTES-1:0][7:0] name_chars_t;

  localparam code_t UNKNOWN_CODE = 5'd25;
  localparam pos_t  POS_MAX      = 5'd31;
  localparam mask_t ALL_NAMES    = {NUM_NAMES{1'b1}};

  // Names are right-aligned: character k of a name of length L sits in byte L-1-k.
  localparam name_chars_t NAME_TABLE [NUM_NAMES] = '{
    "cache-control", "expires", "last-modified", "etag", "connection",
    "keep-alive", "accept", "accept-charset", "accept-encoding",
    "accept-language", "cookie", "set-cookie", "content-length",
    "content-type", "content-encoding", "content-language",
    "content-location", "host", "user-agent", "allow", "server",
    "transfer-encoding", "te", "trailer", "date"
  };

  localparam pos_t NAME_LEN [NUM_NAMES] = '{
    5'd13, 5'd7, 5'd13, 5'd4, 5'd10, 5'd10, 5'd6, 5'd14, 5'd15,
    5'd15, 5'd6, 5'd10, 5'd14, 5'd12, 5'd16, 5'd16,
    5'd16, 5'd4, 5'd10, 5'd5, 5'd6, 5'd17, 5'd2, 5'd7, 5'd4
  };

  // Compare result for one byte: surviving candidates and whole-name hits.
  typedef struct packed {
    mask_t cand;
    mask_t hit;
  } match_t;

  // Map upper case ASCII letters to lower case, pass everything else.
  function automatic byte_t fold_case(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hdl/hhnc_match.sv =====
// Parallel per-name byte compare of the HTTP header name classifier.
// Depends on hhnc_pkg for the name table, lengths and the match_t struct.
module hhnc_match (
  input  hhnc_pkg::byte_t  name_byte,
  input  hhnc_pkg::pos_t   pos,
  input  hhnc_pkg::mask_t  cand,
  output hhnc_pkg::match_t res
);

  hhnc_pkg::byte_t folded;
  hhnc_pkg::mask_t keep;
  hhnc_pkg::mask_t last_pos;

  assign folded = hhnc_pkg::fold_case(name_byte);

  for (genvar i = 0; i < hhnc_pkg::NUM_NAMES; i++) begin : g_name
    localparam hhnc_pkg::pos_t LAST_IDX = hhnc_pkg::NAME_LEN[i] - 5'd1;
    localparam hhnc_pkg::name_chars_t CHARS = hhnc_pkg::NAME_TABLE[i];
    hhnc_pkg::pos_t slot;

    // Wraps past the name's end; the range check masks that case.
    assign slot        = LAST_IDX - pos;
    assign keep[i]     = (pos < hhnc_pkg::NAME_LEN[i]) && (CHARS[slot] == folded);
    assign last_pos[i] = (pos == LAST_IDX);
  end

  assign res.cand = cand & keep;
  assign res.hit  = cand & keep & last_pos;

endmodule

// ===== hdl/http_header_name_classifier_unit.sv =====
// Top level of the HTTP header name classifier: input register, state, result register.
// Depends on hhnc_pkg, hhnc_match and http_header_name_classifier_unit_macros.svh.
//
// Usage:
//   The in_ channel carries one byte of a header field name per transaction,
//   in_tlast marks the final byte of the name and in_tuser starts a new
//   message (all seen flags cleared before that byte is used).
//   One out_ transaction follows each name: header code 0..24 in table order
//   or 25 for an unknown name, the already-seen flag on out_tuser, and the
//   seen flags after the name.
//   The last byte is taken into the input register and the result register
//   loads from it, unless a previous result is still held by the receiver.
//   Throughput: one byte per cycle while no last byte waits on a held result,
//   set by the combinational compare of a byte against all 25 names.
//   A non-last byte never waits on the output side; a last byte waits in the
//   input register only while a previous result is held by the receiver, and
//   in_tready drops only then. Held results keep their values until taken.
//   Reset (rst_n low, synchronous) empties both registers, clears the seen
//   flags and restarts name matching at the first byte.
`include "http_header_name_classifier_unit_macros.svh"

module http_header_name_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] name_byte
  input  logic        in_tlast,   // is_last
  input  logic        in_tuser,   // clear_seen
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [4:0] header_code, [29:5] seen_flags, [31:30] zero
  output logic        out_tuser   // already_seen
);

  // Input register
  logic            s1_valid_r, s1_valid_nxt;
  hhnc_pkg::byte_t s1_byte_r;
  logic            s1_last_r;
  logic            s1_clear_r;

  // Matching state
  hhnc_pkg::mask_t cand_r, cand_nxt;
  hhnc_pkg::pos_t  pos_r, pos_nxt;
  hhnc_pkg::mask_t seen_r, seen_nxt;

  // Result register
  logic            out_valid_r, out_valid_nxt;
  hhnc_pkg::code_t out_code_r;
  logic            out_before_r;
  hhnc_pkg::mask_t out_flags_r;

  logic             in_fire;
  logic             s1_go;
  hhnc_pkg::match_t m;
  hhnc_pkg::mask_t  seen_base;
  hhnc_pkg::mask_t  seen_upd;
  hhnc_pkg::code_t  hit_code;
  logic             seen_before;

  // Advance the input register when its byte needs no output slot or one is free.
  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  hhnc_match u_match (
    .name_byte (s1_byte_r),
    .pos       (pos_r),
    .cand      (cand_r),
    .res       (m)
  );

  // Names are distinct, so at most one whole-name hit: encode by OR-ing codes.
  always_comb begin
    hit_code = '0;
    for (int i = 0; i < hhnc_pkg::NUM_NAMES; i++) begin
      if (m.hit[i]) begin
        hit_code = hit_code | hhnc_pkg::code_t'(i);
      end
    end
    if (m.hit == '0) begin
      hit_code = hhnc_pkg::UNKNOWN_CODE;
    end
  end

  // Clear flags first on a new message, then record this name's hit.
  assign seen_base   = s1_clear_r ? '0 : seen_r;
  assign seen_before = |(m.hit & seen_base);
  assign seen_upd    = seen_base | (s1_last_r ? m.hit : '0);

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    cand_nxt      = cand_r;
    pos_nxt       = pos_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
      seen_nxt     = seen_upd;
      if (s1_last_r) begin
        // Rearm matching for the next name and emit the result.
        cand_nxt      = hhnc_pkg::ALL_NAMES;
        pos_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        cand_nxt = m.cand;
        pos_nxt  = (pos_r == hhnc_pkg::POS_MAX) ? pos_r : pos_r + 5'd1;
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      cand_r      <= hhnc_pkg::ALL_NAMES;
      pos_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      cand_r      <= cand_nxt;
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: input ones load on an input transaction, result ones when a last byte advances; hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_tdata;
      s1_last_r  <= in_tlast;
      s1_clear_r <= in_tuser;
    end
    if (s1_go && s1_last_r) begin
      out_code_r   <= hit_code;
      out_before_r <= seen_before;
      out_flags_r  <= seen_upd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_flags_r, out_code_r};
  assign out_tuser  = out_before_r;

  `HHNC_ASSERT(a_hit_onehot0, s1_valid_r |-> $onehot0(m.hit))
  `HHNC_ASSERT(a_code_range, out_valid_r |-> (out_code_r <= hhnc_pkg::UNKNOWN_CODE))
  `HHNC_ASSERT(a_hit_flag_set,
    (out_valid_r && out_code_r != hhnc_pkg::UNKNOWN_CODE) |-> out_flags_r[out_code_r])
  `HHNC_ASSERT(a_unknown_not_seen,
    (out_valid_r && out_code_r == hhnc_pkg::UNKNOWN_CODE) |-> !out_before_r)
  `HHNC_ASSERT(a_rearm_after_last,
    (s1_go && s1_last_r) |=> (pos_r == '0 && cand_r == hhnc_pkg::ALL_NAMES))

endmodule

// ===== test/testbench.sv =====
// Testbench for http_header_name_classifier_unit: streams header field names byte by byte
// and checks every result against a scoreboard that holds its own name-matching predictor.
// Depends on hhnc_pkg and the RTL under hdl/.

// One classification result as the block should present it.
typedef struct packed {
  hhnc_pkg::code_t code;
  logic            seen_before;
  hhnc_pkg::mask_t flags;
} hdr_result_t;

// Tracks the per-name candidate bits, byte position and seen flags, and holds the
// results still owed by the block.
class hdr_scoreboard;
  string           known [hhnc_pkg::NUM_NAMES];
  hhnc_pkg::mask_t cand;
  int              name_pos;
  hhnc_pkg::mask_t seen;
  hdr_result_t     expected_q [$];
  int              mismatches;

  function new();
    known = '{"cache-control", "expires", "last-modified", "etag", "connection",
              "keep-alive", "accept", "accept-charset", "accept-encoding",
              "accept-language", "cookie", "set-cookie", "content-length",
              "content-type", "content-encoding", "content-language",
              "content-location", "host", "user-agent", "allow", "server",
              "transfer-encoding", "te", "trailer", "date"};
    cand       = hhnc_pkg::ALL_NAMES;
    name_pos   = 0;
    seen       = '0;
    mismatches = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Advance the matcher by one accepted byte; a last byte yields one expected result.
  function void note_byte(hhnc_pkg::byte_t raw, logic is_last, logic clr);
    hhnc_pkg::byte_t c;
    hhnc_pkg::mask_t keep;
    int              code;
    hdr_result_t     r;
    c = raw;
    if (raw >= 8'h41 && raw <= 8'h5A) c = raw | 8'h20;
    if (clr) seen = '0;
    keep = '0;
    for (int i = 0; i < hhnc_pkg::NUM_NAMES; i++) begin
      if (name_pos < known[i].len() && known[i][name_pos] == c) keep[i] = 1'b1;
    end
    cand = cand & keep;
    if (!is_last) begin
      if (name_pos < 31) name_pos++;
      return;
    end
    code = int'(hhnc_pkg::UNKNOWN_CODE);
    for (int i = hhnc_pkg::NUM_NAMES - 1; i >= 0; i--) begin
      if (cand[i] && known[i].len() == name_pos + 1) code = i;
    end
    r.code        = code[4:0];
    r.seen_before = 1'b0;
    if (code < hhnc_pkg::NUM_NAMES) begin
      r.seen_before = seen[code];
      seen[code]    = 1'b1;
    end
    r.flags = seen;
    expected_q.push_back(r);
    cand     = hhnc_pkg::ALL_NAMES;
    name_pos = 0;
  endfunction

  function void check_result(logic [31:0] data, logic user);
    hdr_result_t want;
    if (expected_q.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result: code %0d seen %0b flags %h", data[4:0], user, data[29:5]);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (data[4:0] !== want.code || user !== want.seen_before || data[29:5] !== want.flags) begin
      if (mismatches < 10)
        $display("mismatch: expected code %0d seen %0b flags %h, got code %0d seen %0b flags %h",
                 want.code, want.seen_before, want.flags, data[4:0], user, data[29:5]);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  hdr_scoreboard   sb;
  hhnc_pkg::byte_t name_q [$];   // bytes of the name being sent
  int              bytes_sent;
  int              rx_stall;
  bit              rx_calm;
  bit              tx_calm;

  http_header_name_classifier_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Idle length: mostly none or short, now and then a long one; none at all in a calm stretch.
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Randomly raise a lower case letter to upper case; the block must not care.
  function automatic hhnc_pkg::byte_t mix_case(hhnc_pkg::byte_t c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) return c - 8'h20;
    return c;
  endfunction

  // Sample both channels at the rising edge; the DUT updates its registers after this.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast, in_tuser);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // Result side backpressure: stall at random, with calm stretches that take every result.
  initial begin
    out_tready = 1'b0;
    rx_stall   = 0;
    rx_calm    = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (rx_stall > 0) begin
        out_tready = 1'b0;
        rx_stall--;
      end else begin
        out_tready = 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_stall = idle_len(1'b0);
      end
    end
  end

  // Offer one byte after a random idle gap and hold it until the block takes it.
  task automatic send_byte(hhnc_pkg::byte_t b, bit is_last, bit clr);
    int gap;
    gap = idle_len(tx_calm);
    @(negedge clk);
    repeat (gap) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = is_last;
    in_tuser  = clr;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Send name_q as one name; clear on the first byte if asked, plus rare stray clears.
  task automatic send_name(bit clr_first, bit stray_clr);
    bit clr;
    tx_calm = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < name_q.size(); k++) begin
      clr = (k == 0 && clr_first) || (stray_clr && $urandom_range(0, 63) == 0);
      send_byte(name_q[k], k == name_q.size() - 1, clr);
    end
  endtask

  task automatic load_name(int idx);
    name_q.delete();
    for (int k = 0; k < sb.known[idx].len(); k++) name_q.push_back(mix_case(sb.known[idx][k]));
  endtask

  // Hold the sender until the block has delivered everything owed.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Build one random name: mostly known names, some bent out of shape, some noise.
  task automatic build_random_name();
    string alpha;
    int    r;
    int    n;
    alpha = "acdeghiklmnoprstuxy-";
    r     = $urandom_range(0, 99);
    if (r < 70) begin
      load_name($urandom_range(0, hhnc_pkg::NUM_NAMES - 1));
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, name_q.size());
          while (name_q.size() > n) void'(name_q.pop_back());
        end
        1: name_q.push_back(mix_case(alpha[$urandom_range(0, alpha.len() - 1)]));
        2: name_q[$urandom_range(0, name_q.size() - 1)] = hhnc_pkg::byte_t'($urandom_range(0, 255));
        default: ;
      endcase
    end else if (r < 85) begin
      name_q.delete();
      n = $urandom_range(1, 8);
      repeat (n) name_q.push_back(mix_case(alpha[$urandom_range(0, alpha.len() - 1)]));
    end else if (r < 94) begin
      name_q.delete();
      n = $urandom_range(1, 6);
      repeat (n) name_q.push_back(hhnc_pkg::byte_t'($urandom_range(0, 255)));
    end else begin
      // overlong: drives the position counter into saturation
      load_name($urandom_range(0, hhnc_pkg::NUM_NAMES - 1));
      n = $urandom_range(32, 40);
      while (name_q.size() < n) name_q.push_back(mix_case(alpha[$urandom_range(0, alpha.len() - 1)]));
    end
  endtask

  initial begin
    sb         = new();
    bytes_sent = 0;
    tx_calm    = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    in_tuser   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every known name once, mixed case, opening a new message.
    for (int i = 0; i < hhnc_pkg::NUM_NAMES; i++) begin
      load_name(i);
      send_name(i == 0, 1'b0);
    end
    // Repeats report already seen.
    load_name(17);
    send_name(1'b0, 1'b0);
    load_name(7);
    send_name(1'b0, 1'b0);
    // Prefix of a longer name is unknown: "accept-".
    load_name(7);
    while (name_q.size() > 7) void'(name_q.pop_back());
    send_name(1'b0, 1'b0);
    // Known name with one extra character is unknown.
    load_name(7);
    name_q.push_back("x");
    send_name(1'b0, 1'b0);
    // Overlong name, well past the saturation point.
    load_name(16);
    repeat (20) name_q.push_back("a");
    send_name(1'b0, 1'b0);
    // Non-ASCII bytes match nothing, even with the low seven bits of a letter.
    load_name(17);
    name_q[0] = 8'hE8;
    send_name(1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    // Clear on the last byte: flags drop, then "te" is recorded fresh.
    send_byte("T", 1'b0, 1'b0);
    send_byte("e", 1'b1, 1'b1);
    // Clear in the middle of a name.
    send_byte("d", 1'b0, 1'b0);
    send_byte("A", 1'b0, 1'b0);
    send_byte("t", 1'b0, 1'b1);
    send_byte("e", 1'b1, 1'b0);
    // Single-byte unknown name.
    send_byte("t", 1'b1, 1'b0);
    drain();

    // Random part: mostly well-formed names with random content and case.
    while (bytes_sent < 1450) begin
      build_random_name();
      send_name($urandom_range(0, 9) == 0, 1'b1);
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== http_header_name_classifier_unit.f =====
+incdir+hdl
hdl/hhnc_pkg.sv
hdl/hhnc_match.sv
hdl/http_header_name_classifier_unit.sv
test/testbench.sv
